>>> hw/rtl/vint_pkg.sv
// Shared types, command codes and value-width helpers for the varint codec.
// Used by vint_ctrl, vint_dp and varint_codec_signed_unsigned; depends on nothing.
package vint_pkg;

	// Width of the values the codec works on; 64 is the maximum.
	localparam int VALUE_BITS = 64;

	// Number of 7-bit groups needed to cover a full 64-bit value.
	localparam int NUM_GROUPS = 10;
	localparam int GROUP_BITS = 7;
	localparam int WORK_BITS  = NUM_GROUPS * GROUP_BITS;
	localparam int CNT_BITS   = $clog2(NUM_GROUPS);

	// Command codes carried by the input item.
	localparam logic [1:0] CMD_ENC_U = 2'd0;
	localparam logic [1:0] CMD_ENC_S = 2'd1;
	localparam logic [1:0] CMD_DEC_U = 2'd2;
	localparam logic [1:0] CMD_DEC_S = 2'd3;

	// Byte format bits.
	localparam int MORE_POS = 7;
	localparam int SIGN_POS = 6;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] value;
		logic [7:0]  in_byte;
	} req_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        last;
		logic [63:0] decoded_value;
		logic        value_valid;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_enc;
		logic dec;
		logic emit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic last_group;
	} dp_status_t;

	// Keep only the low VALUE_BITS bits.
	function automatic logic [63:0] width_mask(input logic [63:0] x);
		logic [63:0] mask;
		mask = {64{1'b1}} >> (64 - VALUE_BITS);
		return x & mask;
	endfunction

	// Sign-extend from bit VALUE_BITS-1 to 64 bits.
	function automatic logic [63:0] sign_extend(input logic [63:0] x);
		logic [63:0] top;
		top = 64'(1) << (VALUE_BITS - 1);
		return (width_mask(x) ^ top) - top;
	endfunction

endpackage

>>> hw/rtl/vint_ctrl.sv
// Controller state machine of the varint codec: input handshake and encode sequencing.
// Depends on vint_pkg; drives vint_dp through ctrl_cmd_t and reads dp_status_t.
module vint_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic [1:0]             command,
	input  vint_pkg::dp_status_t   status,
	output logic                   req_stall,
	output vint_pkg::ctrl_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;
	logic is_dec;

	// An item is taken only when idle and the result register can take a result.
	assign req_stall = (state_q != ST_IDLE) || !status.out_free;
	assign accept    = req_valid && !req_stall;
	assign is_dec    = (command == vint_pkg::CMD_DEC_U) || (command == vint_pkg::CMD_DEC_S);

	// Command decode and next state.
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_dec) begin
						cmd.dec = 1'b1;
					end else begin
						cmd.load_enc = 1'b1;
						state_d      = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.last_group) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/vint_dp.sv
// Datapath of the varint codec: group register, byte counter, decode accumulator
// and the result register. Depends on vint_pkg; commanded by vint_ctrl.
module vint_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vint_pkg::req_t         req,
	input  vint_pkg::ctrl_cmd_t    cmd,
	input  logic                   rsp_stall,
	output vint_pkg::dp_status_t   status,
	output logic                   rsp_valid,
	output vint_pkg::rsp_t         rsp
);

	localparam int GB = vint_pkg::GROUP_BITS;
	localparam int NG = vint_pkg::NUM_GROUPS;
	localparam int WB = vint_pkg::WORK_BITS;
	localparam int CB = vint_pkg::CNT_BITS;

	logic [63:0]   acc_q;
	logic [WB-1:0] work_q;
	logic          sign_q;
	logic          signed_q;
	logic [CB-1:0] cnt_q;
	logic          rvalid_q;
	vint_pkg::rsp_t rsp_q;

	logic          enc_signed;
	logic [63:0]   enc_val;
	logic          enc_neg;
	logic [63:0]   enc_mag;
	logic [WB-1:0] enc_work;
	logic [CB-1:0] enc_top;

	logic [GB-1:0] grp_sel;
	logic [7:0]    enc_byte;

	logic          dec_more;
	logic [63:0]   dec_u;
	logic [63:0]   dec_s;
	logic [63:0]   dec_val;

	// Encode setup: magnitude and group alignment. A signed value's lowest
	// group holds only six bits, so its magnitude is placed one bit up.
	always_comb begin
		enc_signed = (req.command == vint_pkg::CMD_ENC_S);
		enc_val    = enc_signed ? vint_pkg::sign_extend(req.value)
		                        : vint_pkg::width_mask(req.value);
		enc_neg    = enc_signed && enc_val[63];
		enc_mag    = enc_neg ? ~enc_val : enc_val;
		if (enc_signed) begin
			enc_work = {5'b0, enc_mag, 1'b0};
		end else begin
			enc_work = {6'b0, enc_mag};
		end
	end

	// Index of the most significant nonzero group above the lowest one.
	always_comb begin
		enc_top = '0;
		for (int g = 1; g < NG; g++) begin
			if (|enc_work[g*GB +: GB]) begin
				enc_top = CB'(g);
			end
		end
	end

	// Select the group that the counter points at.
	always_comb begin
		grp_sel = '0;
		for (int g = 0; g < NG; g++) begin
			if (cnt_q == CB'(g)) begin
				grp_sel = work_q[g*GB +: GB];
			end
		end
	end

	// Continuation bytes carry seven bits; the final byte carries the sign when signed.
	always_comb begin
		if (cnt_q != '0) begin
			enc_byte = {1'b1, grp_sel};
		end else if (signed_q) begin
			enc_byte = {1'b0, sign_q, work_q[6:1]};
		end else begin
			enc_byte = {1'b0, work_q[6:0]};
		end
	end

	// Decode of one byte against the accumulator.
	always_comb begin
		dec_more = req.in_byte[vint_pkg::MORE_POS];
		dec_u    = {acc_q[56:0], req.in_byte[6:0]};
		dec_s    = {acc_q[57:0], req.in_byte[5:0]} ^ {64{req.in_byte[vint_pkg::SIGN_POS]}};
		if (dec_more) begin
			dec_val = '0;
		end else if (req.command == vint_pkg::CMD_DEC_U) begin
			dec_val = vint_pkg::width_mask(dec_u);
		end else begin
			dec_val = vint_pkg::sign_extend(dec_s);
		end
	end

	// Decode accumulator: shifts on continuation bytes, clears on the terminal byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.dec) begin
			if (dec_more) begin
				acc_q <= dec_u;
			end else begin
				acc_q <= '0;
			end
		end
	end

	// Group counter counts down from the top group to the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_enc) begin
			cnt_q <= enc_top;
		end else if (cmd.emit && (cnt_q != '0)) begin
			cnt_q <= cnt_q - CB'(1);
		end
	end

	// Encode operand registers.
	always_ff @(posedge clk) begin
		if (cmd.load_enc) begin
			work_q   <= enc_work;
			sign_q   <= enc_neg;
			signed_q <= enc_signed;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else if (cmd.dec || cmd.emit) begin
			rvalid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rvalid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (cmd.dec) begin
			rsp_q.out_byte      <= '0;
			rsp_q.byte_valid    <= 1'b0;
			rsp_q.last          <= 1'b1;
			rsp_q.decoded_value <= dec_val;
			rsp_q.value_valid   <= !dec_more;
		end else if (cmd.emit) begin
			rsp_q.out_byte      <= enc_byte;
			rsp_q.byte_valid    <= 1'b1;
			rsp_q.last          <= (cnt_q == '0);
			rsp_q.decoded_value <= '0;
			rsp_q.value_valid   <= 1'b0;
		end
	end

	assign status.out_free   = !rvalid_q || !rsp_stall;
	assign status.last_group = (cnt_q == '0);
	assign rsp_valid         = rvalid_q;
	assign rsp               = rsp_q;

endmodule

>>> hw/rtl/varint_codec_signed_unsigned.sv
// Varint codec, most significant group first. Decode: one byte per item, result
// registered the cycle after acceptance, a new byte every cycle while output keeps up.
// Encode: an item yields n = 1 to 10 bytes, one per cycle from the group counter while
// output keeps up, then the next item is taken. Results sit in one output register.
// Reset (arst_n, asynchronous, active low) clears the accumulator, controller and valid.
module varint_codec_signed_unsigned (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  vint_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output vint_pkg::rsp_t  rsp
);

	vint_pkg::ctrl_cmd_t  cmd;
	vint_pkg::dp_status_t status;

	// Controller: handshake and byte sequencing.
	vint_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.command   (req.command),
		.status    (status),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	// Datapath: encode groups, decode accumulator and result register.
	vint_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
